>>> rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the bit-level I2C master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned PH_W        = 5;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [PH_W-1:0] COND_LAST = PH_W'(3);
  localparam logic [PH_W-1:0] ACK_PHASE = PH_W'(1 + 3 * BYTE_BITS);
  localparam logic [PH_W-1:0] BYTE_LAST = PH_W'(3 * BYTE_BITS + 3);

  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_STOP      = 3'd1,
    OP_WRITE     = 3'd2,
    OP_READ_ACK  = 3'd3,
    OP_READ_NACK = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    SLOT_DATA = 2'd0,
    SLOT_HIGH = 2'd1,
    SLOT_LOW  = 2'd2
  } slot_t;

  typedef struct packed {
    logic                 cmd_valid;
    logic [2:0]           opcode;
    logic [BYTE_BITS-1:0] write_data;
    logic                 sda_in;
  } in_item_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_drive_enable;
    logic                 sda_drive_level;
    logic                 busy_res;
    logic [BYTE_BITS-1:0] read_data;
    logic                 read_valid;
  } out_item_t;

  // classified tick handed from front to back
  typedef struct packed {
    logic                 cmd_ok;
    op_t                  op;
    logic [BYTE_BITS-1:0] wdata;
    logic                 sda;
  } tick_t;

endpackage

>>> rtl/i2cm_fifo.sv
// ----------------------------------------------------------------------------
// i2cm_fifo
// Small synchronous queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module i2cm_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts ticks, classifies the offered command and queues the tick.
// ----------------------------------------------------------------------------
module i2cm_front #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  i2cm_pkg::in_item_t  in_data,
  output logic                full,
  output logic                tick_valid,
  output i2cm_pkg::tick_t     tick,
  input  logic                tick_pop
);
  import i2cm_pkg::*;

  tick_t cls;
  logic  q_empty;

  always_comb begin
    cls.cmd_ok = in_data.cmd_valid && (in_data.opcode <= 3'(OP_READ_NACK));
    cls.op     = cls.cmd_ok ? op_t'(in_data.opcode) : OP_START;
    cls.wdata  = in_data.write_data;
    cls.sda    = in_data.sda_in;
  end

  i2cm_fifo #(
    .W     ($bits(tick_t)),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cls),
    .full      (full),
    .pop       (tick_pop),
    .pop_data  (tick),
    .empty     (q_empty)
  );

  assign tick_valid = ~q_empty;

endmodule

>>> rtl/i2cm_back.sv
// ----------------------------------------------------------------------------
// i2cm_back
// Bit engine: steps the start/stop/byte phase plan once per tick and
// queues the line levels and read byte for each tick.
// ----------------------------------------------------------------------------
module i2cm_back #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tick_valid,
  input  i2cm_pkg::tick_t     tick,
  output logic                tick_pop,
  output logic                empty,
  input  logic                pop,
  output i2cm_pkg::out_item_t out_data
);
  import i2cm_pkg::*;

  logic [PH_W-1:0]      ph_r, ph_nxt;
  slot_t                slot_r, slot_nxt;
  op_t                  cmd_r, cmd_nxt;
  logic [BYTE_BITS-1:0] sh_r, sh_nxt;
  logic                 busy_r, busy_nxt;
  logic                 scl_r, scl_nxt;
  logic                 en_r, en_nxt;
  logic                 lvl_r, lvl_nxt;
  logic [BYTE_BITS-1:0] rd_r, rd_nxt;
  logic                 pulse;
  logic [PH_W-1:0]      p;
  logic [PH_W-1:0]      last;
  logic                 oq_full;
  out_item_t            res;

  assign tick_pop = tick_valid & ~oq_full;

  always_comb begin
    busy_nxt = busy_r;
    cmd_nxt  = cmd_r;
    sh_nxt   = sh_r;
    scl_nxt  = scl_r;
    en_nxt   = en_r;
    lvl_nxt  = lvl_r;
    rd_nxt   = rd_r;
    ph_nxt   = ph_r;
    slot_nxt = slot_r;
    pulse    = 1'b0;
    p        = ph_r;
    last     = BYTE_LAST;

    if (!busy_r && tick.cmd_ok) begin
      busy_nxt = 1'b1;
      cmd_nxt  = tick.op;
      p        = '0;
      sh_nxt   = (tick.op == OP_WRITE) ? tick.wdata : '0;
    end

    if (busy_nxt) begin
      case (cmd_nxt)
        OP_START: begin
          last = COND_LAST;
          case (p[1:0])
            2'd0:    en_nxt = 1'b0;
            2'd1:    scl_nxt = 1'b1;
            2'd2:    begin en_nxt = 1'b1; lvl_nxt = 1'b0; end
            default: scl_nxt = 1'b0;
          endcase
        end
        OP_STOP: begin
          last = COND_LAST;
          case (p[1:0])
            2'd0:    scl_nxt = 1'b0;
            2'd1:    begin en_nxt = 1'b1; lvl_nxt = 1'b0; end
            2'd2:    scl_nxt = 1'b1;
            default: en_nxt = 1'b0;
          endcase
        end
        OP_WRITE: begin
          if (p == '0) begin
            en_nxt  = 1'b1;
            lvl_nxt = 1'b1;
          end else if (p < ACK_PHASE) begin
            case (slot_r)
              SLOT_DATA: begin
                lvl_nxt = sh_nxt[BYTE_BITS-1];
                sh_nxt  = {sh_nxt[BYTE_BITS-2:0], 1'b0};
              end
              SLOT_HIGH: scl_nxt = 1'b1;
              default:   scl_nxt = 1'b0;
            endcase
          end else if (p == ACK_PHASE) begin
            en_nxt = 1'b0;
          end else if (p == ACK_PHASE + 1'b1) begin
            scl_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0;
            lvl_nxt = 1'b0;
          end
        end
        default: begin
          if (p == '0) begin
            en_nxt = 1'b0;
          end else if (p < ACK_PHASE) begin
            case (slot_r)
              SLOT_DATA: scl_nxt = 1'b1;
              SLOT_HIGH: sh_nxt = {sh_nxt[BYTE_BITS-2:0], tick.sda};
              default:   scl_nxt = 1'b0;
            endcase
          end else if (p == ACK_PHASE) begin
            lvl_nxt = (cmd_nxt == OP_READ_NACK);
            en_nxt  = 1'b1;
          end else if (p == ACK_PHASE + 1'b1) begin
            scl_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0;
            en_nxt  = 1'b0;
            rd_nxt  = sh_nxt;
            pulse   = 1'b1;
          end
        end
      endcase

      if (p >= last) begin
        busy_nxt = 1'b0;
        ph_nxt   = '0;
      end else begin
        ph_nxt = p + 1'b1;
      end

      // bit slot of the following phase
      if (p == '0) begin
        slot_nxt = SLOT_DATA;
      end else begin
        case (slot_r)
          SLOT_DATA: slot_nxt = SLOT_HIGH;
          SLOT_HIGH: slot_nxt = SLOT_LOW;
          default:   slot_nxt = SLOT_DATA;
        endcase
      end
    end

    res.scl_level        = scl_nxt;
    res.sda_drive_enable = en_nxt;
    res.sda_drive_level  = lvl_nxt;
    res.busy_res         = busy_nxt;
    res.read_data        = rd_nxt;
    res.read_valid       = pulse;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= '0;
      slot_r <= SLOT_DATA;
      cmd_r  <= OP_START;
      sh_r   <= '0;
      busy_r <= 1'b0;
      scl_r  <= 1'b1;
      en_r   <= 1'b0;
      lvl_r  <= 1'b0;
      rd_r   <= '0;
    end else if (tick_pop) begin
      ph_r   <= ph_nxt;
      slot_r <= slot_nxt;
      cmd_r  <= cmd_nxt;
      sh_r   <= sh_nxt;
      busy_r <= busy_nxt;
      scl_r  <= scl_nxt;
      en_r   <= en_nxt;
      lvl_r  <= lvl_nxt;
      rd_r   <= rd_nxt;
    end
  end

  i2cm_fifo #(
    .W     ($bits(out_item_t)),
    .DEPTH (DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tick_pop),
    .push_data (res),
    .full      (oq_full),
    .pop       (pop),
    .pop_data  (out_data),
    .empty     (empty)
  );

endmodule

>>> rtl/i2c_bit_level_master.sv
// Path: an accepted item is stored in the tick queue; the bit engine's result
//   for it is then written to the output queue, from which it can be popped.
// Throughput: one item per cycle while the output queue has room.
// Reset: synchronous, active low; queues empty, SCL high, SDA released,
//   engine idle, read byte zero.
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// Bit-level I2C master: front classifier, tick queue and bit engine.
// ----------------------------------------------------------------------------
module i2c_bit_level_master #(
  parameter int unsigned QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  i2cm_pkg::in_item_t  in_data,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output i2cm_pkg::out_item_t out_data
);
  import i2cm_pkg::*;

  logic  tick_valid;
  logic  tick_pop;
  tick_t tick;

  i2cm_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_data    (in_data),
    .full       (full),
    .tick_valid (tick_valid),
    .tick       (tick),
    .tick_pop   (tick_pop)
  );

  i2cm_back #(
    .DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_valid (tick_valid),
    .tick       (tick),
    .tick_pop   (tick_pop),
    .empty      (empty),
    .pop        (pop),
    .out_data   (out_data)
  );

endmodule

>>> rtl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks for the bit-level I2C master, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                pop,
  input logic                empty,
  input i2cm_pkg::out_item_t out_data
);

  // results queue is empty straight after reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed");

  // a completed read ends the command: engine idle
  a_read_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.read_valid) |-> !out_data.busy_res)
    else $error("read item while still busy");

  // a completed read leaves SCL low and SDA released
  a_read_lines: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.read_valid) |->
      (!out_data.scl_level && !out_data.sda_drive_enable))
    else $error("bad line levels at read completion");

endmodule

bind i2c_bit_level_master i2cm_checker u_i2cm_checker (.*);

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bit-level I2C master. Bus ticks go in through
// the input queue as whole command sequences: start and stop conditions,
// byte writes and reads, and register-block transfers to device 0x68. Random
// ticks, stray commands while busy and unknown opcodes are mixed in. A
// cycle-true model of the bit engine predicts SCL, SDA drive, busy and the
// read byte for every tick, and each popped result is checked against it.
// ----------------------------------------------------------------------------
module tb;
  import i2cm_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int COND_TICKS  = 4;
  localparam int ACK_SLOT    = 1 + 3 * BYTE_BITS;
  localparam int BYTE_TICKS  = ACK_SLOT + 3;
  localparam int XFER_MAX    = 3 * COND_TICKS + 5 * BYTE_TICKS;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;
  localparam int N_ITEMS     = 450;

  localparam logic [6:0] DEV_ADDR     = 7'h68;
  localparam logic [2:0] OP_FIRST_BAD = 3'(OP_READ_NACK) + 3'd1;
  localparam logic [2:0] OP_LAST_BAD  = 3'd7;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      push    = 1'b0;
  logic      pop     = 1'b0;
  in_item_t  in_data = '0;
  logic      full;
  logic      empty;
  out_item_t out_data;

  // model of the bit engine
  logic [4:0]           m_phase   = '0;
  op_t                  m_op      = OP_START;
  logic [BYTE_BITS-1:0] m_shift   = '0;
  logic                 m_busy    = 1'b0;
  logic                 m_scl     = 1'b1;
  logic                 m_sda_en  = 1'b0;
  logic                 m_sda_lvl = 1'b0;
  logic [BYTE_BITS-1:0] m_rd      = '0;

  out_item_t bus_states[$];
  int        mismatches  = 0;
  int        ticks_sent  = 0;
  int        stall_cnt   = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  bit        hold_rx     = 1'b0;

  i2c_bit_level_master DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

  always #HALF_PERIOD clk = ~clk;

  task automatic i2c_tick(input in_item_t it, output out_item_t o);
    int    p;
    int    last;
    slot_t k;
    logic  done;
    done = 1'b0;
    last = 0;
    if (!m_busy && it.cmd_valid && it.opcode <= OP_READ_NACK) begin
      m_busy  = 1'b1;
      m_op    = op_t'(it.opcode);
      m_phase = '0;
      m_shift = (m_op == OP_WRITE) ? it.write_data : '0;
    end
    if (m_busy) begin
      p = m_phase;
      k = slot_t'((p + 2) % 3);
      case (m_op)
        OP_START: begin
          last = COND_TICKS - 1;
          case (p)
            0: m_sda_en = 1'b0;
            1: m_scl = 1'b1;
            2: begin
              m_sda_en  = 1'b1;
              m_sda_lvl = 1'b0;
            end
            default: m_scl = 1'b0;
          endcase
        end
        OP_STOP: begin
          last = COND_TICKS - 1;
          case (p)
            0: m_scl = 1'b0;
            1: begin
              m_sda_en  = 1'b1;
              m_sda_lvl = 1'b0;
            end
            2: m_scl = 1'b1;
            default: m_sda_en = 1'b0;
          endcase
        end
        OP_WRITE: begin
          last = BYTE_TICKS - 1;
          if (p == 0) begin
            m_sda_en  = 1'b1;
            m_sda_lvl = 1'b1;
          end else if (p < ACK_SLOT) begin
            case (k)
              SLOT_DATA: begin
                m_sda_lvl = m_shift[BYTE_BITS-1];
                m_shift   = m_shift << 1;
              end
              SLOT_HIGH: m_scl = 1'b1;
              default: m_scl = 1'b0;
            endcase
          end else if (p == ACK_SLOT) begin
            m_sda_en = 1'b0;
          end else if (p == ACK_SLOT + 1) begin
            m_scl = 1'b1;
          end else begin
            m_scl     = 1'b0;
            m_sda_lvl = 1'b0;
          end
        end
        default: begin
          last = BYTE_TICKS - 1;
          if (p == 0) begin
            m_sda_en = 1'b0;
          end else if (p < ACK_SLOT) begin
            case (k)
              SLOT_DATA: m_scl = 1'b1;
              SLOT_HIGH: m_shift = {m_shift[BYTE_BITS-2:0], it.sda_in};
              default: m_scl = 1'b0;
            endcase
          end else if (p == ACK_SLOT) begin
            m_sda_lvl = (m_op == OP_READ_NACK);
            m_sda_en  = 1'b1;
          end else if (p == ACK_SLOT + 1) begin
            m_scl = 1'b1;
          end else begin
            m_scl    = 1'b0;
            m_sda_en = 1'b0;
            m_rd     = m_shift;
            done     = 1'b1;
          end
        end
      endcase
      if (p >= last) begin
        m_busy  = 1'b0;
        m_phase = '0;
      end else begin
        m_phase = 5'(p + 1);
      end
    end
    o.scl_level        = m_scl;
    o.sda_drive_enable = m_sda_en;
    o.sda_drive_level  = m_sda_lvl;
    o.busy_res         = m_busy;
    o.read_data        = m_rd;
    o.read_valid       = done;
  endtask

  task automatic compare_bus(input out_item_t got);
    out_item_t want;
    string     bad;
    if (bus_states.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: result %h popped with no item outstanding", $realtime, got);
      return;
    end
    want = bus_states.pop_front();
    bad  = "";
    if (got.scl_level !== want.scl_level) bad = {bad, " scl_level"};
    if (got.sda_drive_enable !== want.sda_drive_enable) bad = {bad, " sda_drive_enable"};
    if (got.sda_drive_level !== want.sda_drive_level) bad = {bad, " sda_drive_level"};
    if (got.busy_res !== want.busy_res) bad = {bad, " busy_res"};
    if (got.read_data !== want.read_data) bad = {bad, " read_data"};
    if (got.read_valid !== want.read_valid) bad = {bad, " read_valid"};
    if (bad != "") begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("%0t: mismatch in%s", $realtime, bad);
        $display("  exp scl=%b en=%b lvl=%b busy=%b rd=%h rv=%b",
                 want.scl_level, want.sda_drive_enable, want.sda_drive_level,
                 want.busy_res, want.read_data, want.read_valid);
        $display("  got scl=%b en=%b lvl=%b busy=%b rd=%h rv=%b",
                 got.scl_level, got.sda_drive_enable, got.sda_drive_level,
                 got.busy_res, got.read_data, got.read_valid);
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      if (push && !full) begin
        i2c_tick(in_data, want);
        bus_states.push_back(want);
      end
      if (pop && !empty) compare_bus(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int gap_len(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(3);
    return (r == 0) ? 0 : (r == 1) ? 10 : 35;
  endfunction

  initial begin : receiver
    int gap;
    gap = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rx = 1'b0;
        pop <= 1'b1;
      end else if (gap > 0) begin
        pop <= 1'b0;
        gap--;
      end else begin
        pop <= 1'b1;
        gap = gap_len(rx_idle_pct);
      end
    end
  end

  task automatic send_tick(input in_item_t it);
    int gap;
    gap = gap_len(tx_idle_pct);
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push    <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    ticks_sent++;
  endtask

  // one command plus the ticks it runs for; noisy adds stray commands and SDA
  task automatic issue(input op_t op, input logic [7:0] wbyte, input logic [7:0] rbyte,
                       input bit noisy);
    int       len;
    int       p;
    in_item_t it;
    len = (op == OP_START || op == OP_STOP) ? COND_TICKS : BYTE_TICKS;
    for (p = 0; p < len; p++) begin
      it.cmd_valid  = (p == 0) ? 1'b1 : (noisy ? 1'($urandom) : 1'b0);
      it.opcode     = (p == 0) ? op : 3'($urandom_range(0, 7));
      it.write_data = (p == 0) ? wbyte : 8'($urandom);
      it.sda_in     = noisy ? 1'($urandom) : 1'b1;
      if (p >= 1 && p < ACK_SLOT && (p - 1) % 3 == 1)
        it.sda_in = rbyte[BYTE_BITS - 1 - (p - 1) / 3];
      send_tick(it);
    end
  endtask

  // idle ticks: no command or an unknown opcode
  task automatic send_noise(input int n);
    in_item_t it;
    repeat (n) begin
      it.cmd_valid  = 1'($urandom);
      it.opcode     = it.cmd_valid ? 3'($urandom_range(OP_FIRST_BAD, OP_LAST_BAD))
                                   : 3'($urandom);
      it.write_data = 8'($urandom);
      it.sda_in     = 1'($urandom);
      send_tick(it);
    end
  endtask

  task automatic reg_transfer(input bit rd, input int nbytes, input bit noisy);
    int i;
    issue(OP_START, 8'($urandom), 8'($urandom), noisy);
    issue(OP_WRITE, {DEV_ADDR, 1'b0}, 8'($urandom), noisy);
    issue(OP_WRITE, 8'($urandom), 8'($urandom), noisy);
    if (rd) begin
      issue(OP_START, 8'($urandom), 8'($urandom), noisy);
      issue(OP_WRITE, {DEV_ADDR, 1'b1}, 8'($urandom), noisy);
      for (i = 0; i < nbytes; i++)
        issue((i == nbytes - 1) ? OP_READ_NACK : OP_READ_ACK, 8'($urandom), 8'($urandom),
              noisy);
    end else begin
      for (i = 0; i < nbytes; i++) issue(OP_WRITE, 8'($urandom), 8'($urandom), noisy);
    end
    issue(OP_STOP, 8'($urandom), 8'($urandom), noisy);
  endtask

  task automatic test_idle_ticks();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_noise(8);
  endtask

  task automatic test_conditions();
    issue(OP_START, 8'hFF, 8'h00, 1'b0);
    issue(OP_STOP, 8'h00, 8'hFF, 1'b1);
  endtask

  task automatic test_write();
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    issue(OP_START, 8'h00, 8'h00, 1'b0);
    issue(OP_WRITE, 8'hFF, 8'h00, 1'b0);
    issue(OP_WRITE, 8'h00, 8'hFF, 1'b1);
    issue(OP_WRITE, {DEV_ADDR, 1'b0}, 8'h00, 1'b1);
  endtask

  task automatic test_read();
    issue(OP_READ_ACK, 8'hFF, 8'hFF, 1'b1);
    issue(OP_READ_NACK, 8'h00, 8'h00, 1'b0);
    issue(OP_READ_ACK, 8'h00, 8'hA5, 1'b0);
    issue(OP_STOP, 8'h00, 8'h00, 1'b0);
    send_noise(3);
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_rx     = 1'b1;
    reg_transfer(1'b1, 1, 1'b1);
  endtask

  // top up to the item budget; whole transfers only while they fit
  task automatic test_random();
    int r;
    while (ticks_sent < N_ITEMS) begin
      tx_idle_pct = pick_idle();
      rx_idle_pct = pick_idle();
      r = $urandom_range(99);
      if (r < 60 && N_ITEMS - ticks_sent >= XFER_MAX)
        reg_transfer(1'($urandom), $urandom_range(1, 2), 1'($urandom));
      else if (r < 85)
        issue(op_t'($urandom_range(OP_START, OP_READ_NACK)), 8'($urandom), 8'($urandom),
              1'($urandom));
      else
        send_noise($urandom_range(1, 6));
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_idle_ticks();
    test_conditions();
    test_write();
    test_read();
    test_backpressure();
    test_random();
    @(negedge clk);
    push <= 1'b0;
    wait (bus_states.size() == 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && bus_states.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
